[hw/rtl/rmf_pkg.sv]
// Shared constants and control types for the running median filter.
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned CFG_W          = 5;
  localparam int unsigned MAX_WINDOW_DEF = 16;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 5'd1;

  // merge engine control from the top level
  typedef struct packed {
    logic start;
    logic drop_old;
  } merge_ctrl_t;

  // merge engine status back to the top level
  typedef struct packed {
    logic done;
    logic even;
  } merge_stat_t;

endpackage

`default_nettype wire

[hw/rtl/rmf_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rmf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rmf_merge.sv]
// Sorted-window merge engine: drops the oldest sample when the window is full, inserts the new one.
`timescale 1ns / 1ps
`default_nettype none

module rmf_merge
  import rmf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1),
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire merge_ctrl_t              ctrl_i,
  input  wire logic        [CNT_W-1:0]  old_len_i,
  input  wire logic        [CNT_W-1:0]  new_len_i,
  input  wire logic signed [DATA_W-1:0] new_val_i,
  input  wire logic signed [DATA_W-1:0] old_val_i,
  output merge_stat_t                   stat_o,
  output logic signed      [DATA_W-1:0] lo_o,
  output logic signed      [DATA_W-1:0] hi_o
);

  localparam int unsigned SORT_AW    = SLOT_W + 1;
  localparam int unsigned SORT_DEPTH = 2 ** SORT_AW;

  typedef enum logic {
    M_IDLE,
    M_RUN
  } mstate_e;

  mstate_e            state_q;
  logic               bank_q;
  logic [CNT_W-1:0]   i_q, j_q, m_q, k_q;
  logic               rem_q, ins_q, even_q;
  logic signed [DATA_W-1:0] y_q, x_q;

  logic               run, avail, take_old, put_new, put_old, consume, finish;
  logic [CNT_W-1:0]   i_nxt;
  logic signed [DATA_W-1:0] v, wr_val;
  logic               re;
  logic [SORT_AW-1:0] raddr, waddr;
  logic [DATA_W-1:0]  rdata;

  assign v     = $signed(rdata);
  assign run   = (state_q == M_RUN);
  assign avail = (i_q != m_q);
  assign i_nxt = i_q + 1'b1;

  // one event per cycle: remove the old sample, emit the new one, or copy one across
  always_comb begin
    take_old = avail && !rem_q && (v == x_q);
    put_new  = !take_old && !ins_q && (!avail || (y_q < v));
    put_old  = !take_old && !put_new && avail;
    consume  = run && (take_old || put_old);
    finish   = run && ins_q && !avail;
    wr_val   = put_new ? y_q : v;
    waddr    = {~bank_q, j_q[SLOT_W-1:0]};
    if (run) begin
      re    = consume && (i_nxt != m_q);
      raddr = {bank_q, i_nxt[SLOT_W-1:0]};
    end else begin
      re    = ctrl_i.start && (old_len_i != '0);
      raddr = {bank_q, {SLOT_W{1'b0}}};
    end
  end

  // the sorted copy ping-pongs between two banks, one per sample
  rmf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SORT_DEPTH)
  ) u_sort_ram (
    .clk_i   (clk_i),
    .we_i    (run && (put_new || put_old)),
    .waddr_i (waddr),
    .wdata_i (wr_val),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      bank_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      m_q     <= '0;
      k_q     <= '0;
      rem_q   <= 1'b0;
      ins_q   <= 1'b0;
      even_q  <= 1'b0;
    end else begin
      unique case (state_q)
        M_IDLE: begin
          if (ctrl_i.start) begin
            state_q <= M_RUN;
            m_q     <= old_len_i;
            k_q     <= new_len_i >> 1;
            even_q  <= ~new_len_i[0];
            y_q     <= new_val_i;
            x_q     <= old_val_i;
            rem_q   <= ~ctrl_i.drop_old;
            ins_q   <= 1'b0;
            i_q     <= '0;
            j_q     <= '0;
          end
        end
        M_RUN: begin
          if (finish) begin
            state_q <= M_IDLE;
            bank_q  <= ~bank_q;
          end
          if (consume) begin
            i_q <= i_nxt;
          end
          if (take_old) begin
            rem_q <= 1'b1;
          end
          if (put_new) begin
            ins_q <= 1'b1;
          end
          if (put_new || put_old) begin
            j_q <= j_q + 1'b1;
            // capture the two middle entries as they stream past
            if (j_q == k_q - 1'b1) begin
              lo_o <= wr_val;
            end
            if (j_q == k_q) begin
              hi_o <= wr_val;
            end
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign stat_o.done = finish;
  assign stat_o.even = even_q;

endmodule

`default_nettype wire

[hw/rtl/rmf_round.sv]
// Two-stage median output: middle value, or mean of two rounded half away from zero.
`timescale 1ns / 1ps
`default_nettype none

module rmf_round
  import rmf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     even_i,
  input  wire logic signed [DATA_W-1:0] lo_i,
  input  wire logic signed [DATA_W-1:0] hi_i,
  output logic                          valid_o,
  output logic             [DATA_W-1:0] median_o
);

  logic              stage_q;
  logic              even_q;
  logic [DATA_W-1:0] hi_q;
  logic [DATA_W:0]   sum_q;
  logic [DATA_W:0]   sum_p1;

  assign sum_p1 = sum_q + {{DATA_W{1'b0}}, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      stage_q <= start_i;
      valid_o <= stage_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      even_q <= even_i;
      hi_q   <= hi_i;
      sum_q  <= {lo_i[DATA_W-1], lo_i} + {hi_i[DATA_W-1], hi_i};
    end
    if (stage_q) begin
      if (!even_q) begin
        median_o <= hi_q;
      end else if (sum_q[DATA_W]) begin
        median_o <= sum_q[DATA_W:1];   // negative: floor halves away from zero
      end else begin
        median_o <= sum_p1[DATA_W:1];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/running_median_filter.sv]
// Running median filter top level: sample ring, control, output register.
// Path to a result: ring read, merge pass, rounding stages, output register.
// A new sample is taken only when idle, after the previous one has passed the merge
// pass over the sorted RAM (one entry per cycle) and reached the output register.
// Reset: asynchronous, active low; window length 1, ring empty, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module running_median_filter
  import rmf_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,  // window_length
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,      // [31:0] sample_in
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic      [DATA_W-1:0] m_tdata       // [31:0] median_out
);

  localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOAD,
    T_WORK,
    T_HOLD
  } tstate_e;

  tstate_e            state_q;
  logic [CNT_W-1:0]   win_q, cnt_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [DATA_W-1:0]  y_q;
  logic               m_tvalid_q;
  logic [DATA_W-1:0]  m_tdata_q;

  logic               s_xfer, out_free, cfg_legal, full, out_load;
  logic [CNT_W-1:0]   new_len, slot_nxt;
  logic [DATA_W-1:0]  ring_rdata;
  merge_ctrl_t        mctrl;
  merge_stat_t        mstat;
  logic signed [DATA_W-1:0] mid_lo, mid_hi;
  logic               rnd_valid;
  logic [DATA_W-1:0]  rnd_median;

  assign s_tready  = (state_q == T_IDLE);
  assign s_xfer    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid_q || m_tready;
  assign cfg_legal = (cfg_wdata_i != '0) && (32'(cfg_wdata_i) <= 32'(MAX_WINDOW));
  assign full      = (cnt_q == win_q);
  assign new_len   = full ? cnt_q : cnt_q + 1'b1;
  assign slot_nxt  = CNT_W'(slot_q) + 1'b1;
  assign out_load  = ((rnd_valid && (state_q == T_WORK)) || (state_q == T_HOLD)) && out_free;

  assign mctrl.start    = (state_q == T_LOAD);
  assign mctrl.drop_old = full;

  // ring keeps arrival order; the oldest entry is read back only to drop it
  rmf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == T_LOAD),
    .waddr_i (slot_q),
    .wdata_i (y_q),
    .re_i    (s_xfer),
    .raddr_i (slot_q),
    .rdata_o (ring_rdata)
  );

  rmf_merge #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mctrl),
    .old_len_i (cnt_q),
    .new_len_i (new_len),
    .new_val_i ($signed(y_q)),
    .old_val_i ($signed(ring_rdata)),
    .stat_o    (mstat),
    .lo_o      (mid_lo),
    .hi_o      (mid_hi)
  );

  rmf_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mstat.done),
    .even_i   (mstat.even),
    .lo_i     (mid_lo),
    .hi_i     (mid_hi),
    .valid_o  (rnd_valid),
    .median_o (rnd_median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      win_q      <= CNT_W'(WINDOW_RESET);
      cnt_q      <= '0;
      slot_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid_q <= 1'b1;
        m_tdata_q  <= rnd_median;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (cfg_we_i && cfg_legal) begin
            win_q  <= CNT_W'(cfg_wdata_i);
            cnt_q  <= '0;
            slot_q <= '0;
          end
          if (s_xfer) begin
            y_q     <= s_tdata;
            state_q <= T_LOAD;
          end
        end
        T_LOAD: begin
          cnt_q   <= new_len;
          slot_q  <= (slot_nxt >= win_q) ? '0 : slot_nxt[SLOT_W-1:0];
          state_q <= T_WORK;
        end
        T_WORK, T_HOLD: begin
          if (rnd_valid || (state_q == T_HOLD)) begin
            state_q <= out_free ? T_IDLE : T_HOLD;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
